>>> rtl/core/ppid_db_pkg.sv
// Shared types and constants for the positional PID controller with deadband.
`default_nettype none

package ppid_db_pkg;

    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 16;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Request kinds carried on the input tuser
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN     = 3'd0,
        REG_KI_GAIN     = 3'd1,
        REG_KD_GAIN     = 3'd2,
        REG_DRIVE_UPPER = 3'd3,
        REG_DRIVE_LOWER = 3'd4,
        REG_DEAD_BAND   = 3'd5
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]         KP_RESET          = 16'd100;
    localparam logic [GAIN_W-1:0]         KI_RESET          = 16'd100;
    localparam logic [GAIN_W-1:0]         KD_RESET          = 16'd5;
    localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RESET = 16'sd1800;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RESET = -16'sd1800;
    localparam logic [GAIN_W-1:0]         DEAD_BAND_RESET   = 16'd3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/core/positional_pid_with_deadband_core.sv
// Positional PID controller with deadband: input register, one-pass compute, result register.
`default_nettype none

// One result per request, one request per cycle sustained while m_tready holds
// the output open. A request is captured in an input register, the error,
// saturating integral, three gain products, halving and clamp are formed in one
// pass, and the result register and the controller state are written together
// at the edge where the request moves on. The per-request figure is set by the
// state loop through the integral adder, the integral multiplier and the clamp,
// which has no register inside it. A clear request zeroes the state and answers
// 0; the gain and clamp registers keep their values.
module positional_pid_with_deadband_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target [SAMPLE_WIDTH-1:0], measured [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // op [0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive [15:0]
    output logic [ppid_db_pkg::DRIVE_W-1:0]     m_tdata,
    // held [0]
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wen,
    input  logic [ppid_db_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppid_db_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ppid_db_pkg::*;

    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int DEW = SAMPLE_WIDTH + 2;
    localparam int SXW = ((EW > SUM_W) ? EW : SUM_W) + 1;
    localparam int CW  = ((EW > GAIN_W) ? EW : GAIN_W) + 1;
    localparam int PPW = GAIN_W + EW + 1;
    localparam int PIW = GAIN_W + SUM_W + 1;
    localparam int PDW = GAIN_W + DEW + 1;
    localparam int PW  = (((PIW > PDW) ? PIW : PDW) > PPW ? ((PIW > PDW) ? PIW : PDW) : PPW) + 2;

    // Configuration registers
    logic [GAIN_W-1:0]         kp_gain_reg;
    logic [GAIN_W-1:0]         ki_gain_reg;
    logic [GAIN_W-1:0]         kd_gain_reg;
    logic signed [DRIVE_W-1:0] drive_upper_reg;
    logic signed [DRIVE_W-1:0] drive_lower_reg;
    logic [GAIN_W-1:0]         dead_band_reg;

    // Controller state
    logic signed [EW-1:0]      last_error_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;
    logic signed [DRIVE_W-1:0] last_drive_reg;

    // Input stage
    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_target_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_measured_reg;

    // Result stage
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;
    logic                      out_held_reg;

    logic advance;

    logic signed [EW-1:0]      err;
    logic signed [DEW-1:0]     derr;
    logic signed [SXW-1:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [CW-1:0]      err_cmp;
    logic signed [CW-1:0]      band;
    logic                      held_next;
    logic signed [PPW-1:0]     prod_p;
    logic signed [PIW-1:0]     prod_i;
    logic signed [PDW-1:0]     prod_d;
    logic signed [PW-1:0]      pid_total;
    logic signed [PW-1:0]      raw_drive;
    logic signed [DRIVE_W-1:0] drive_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_drive_reg;
    assign m_tuser[0] = out_held_reg;

    always_comb
    begin
        err      = EW'(in_target_reg) - EW'(in_measured_reg);
        derr     = DEW'(err) - DEW'(last_error_reg);
        sum_wide = SXW'(error_sum_reg) + SXW'(err);
        if (sum_wide > SXW'(SUM_MAX))
        begin
            sum_sat = SUM_MAX;
        end
        else if (sum_wide < SXW'(SUM_MIN))
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        err_cmp   = CW'(err);
        band      = $signed(CW'(dead_band_reg));
        held_next = (err_cmp < band) && (err_cmp > -band);

        prod_p    = $signed({1'b0, kp_gain_reg}) * err;
        prod_i    = $signed({1'b0, ki_gain_reg}) * sum_sat;
        prod_d    = $signed({1'b0, kd_gain_reg}) * derr;
        pid_total = PW'(prod_p) + PW'(prod_i) + PW'(prod_d);

        // Halve with rounding toward minus infinity
        raw_drive = held_next ? PW'(last_drive_reg) : (pid_total >>> 1);

        // Upper bound is tested first, so with crossed bounds a value at or above the upper one gives the upper one
        if (raw_drive >= PW'(drive_upper_reg))
        begin
            drive_next = drive_upper_reg;
        end
        else if (raw_drive <= PW'(drive_lower_reg))
        begin
            drive_next = drive_lower_reg;
        end
        else
        begin
            drive_next = raw_drive[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg     <= KP_RESET;
            ki_gain_reg     <= KI_RESET;
            kd_gain_reg     <= KD_RESET;
            drive_upper_reg <= DRIVE_UPPER_RESET;
            drive_lower_reg <= DRIVE_LOWER_RESET;
            dead_band_reg   <= DEAD_BAND_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP_GAIN:     kp_gain_reg     <= cfg_wdata;
                REG_KI_GAIN:     ki_gain_reg     <= cfg_wdata;
                REG_KD_GAIN:     kd_gain_reg     <= cfg_wdata;
                REG_DRIVE_UPPER: drive_upper_reg <= $signed(cfg_wdata);
                REG_DRIVE_LOWER: drive_lower_reg <= $signed(cfg_wdata);
                REG_DEAD_BAND:   dead_band_reg   <= cfg_wdata;
                default:         ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            last_drive_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (in_op_reg == OP_CLEAR)
                begin
                    last_error_reg <= '0;
                    error_sum_reg  <= '0;
                    last_drive_reg <= '0;
                end
                else
                begin
                    last_error_reg <= err;
                    error_sum_reg  <= sum_sat;
                    last_drive_reg <= drive_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg       <= s_tuser[0];
            in_target_reg   <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
            in_measured_reg <= $signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
        end
        if (advance)
        begin
            if (in_op_reg == OP_CLEAR)
            begin
                out_drive_reg <= '0;
                out_held_reg  <= 1'b0;
            end
            else
            begin
                out_drive_reg <= drive_next;
                out_held_reg  <= held_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_stall_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting request");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_CLEAR) |=>
        (error_sum_reg == '0 && last_error_reg == '0 && last_drive_reg == '0
         && out_drive_reg == '0 && !out_held_reg))
        else $error("clear request left state or result nonzero");

    a_no_hold_zero_band: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && dead_band_reg == '0) |=> !out_held_reg)
        else $error("drive held with zero deadband");

    a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (last_drive_reg == out_drive_reg))
        else $error("stored drive differs from delivered drive");
`endif

endmodule

`default_nettype wire

>>> verif/ppid_db_checker.sv
// Scoreboard for the positional PID core: predicts every drive result and checks it.
`default_nettype none

module ppid_db_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DATA_W       = ((2*SAMPLE_WIDTH+7)/8)*8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // target, measured, zero pad
    input  logic [DATA_W-1:0]                 s_tdata,
    // op
    input  logic [0:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // drive
    input  logic [ppid_db_pkg::DRIVE_W-1:0]    m_tdata,
    // held
    input  logic [0:0]                        m_tuser,
    input  logic                              cfg_wen,
    input  logic [ppid_db_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppid_db_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                outstanding,
    output int                                mismatches
);
    import ppid_db_pkg::*;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      held;
    } drive_result_t;

    // Controller settings and state, kept at full width
    longint kp_q, ki_q, kd_q, upper_q, lower_q, band_q;
    longint prev_error, error_integral, prev_drive;

    drive_result_t pending_drives[$];
    drive_result_t want;
    int            fail_total;

    function automatic drive_result_t step_controller(
        logic op,
        logic signed [SAMPLE_WIDTH-1:0] tgt,
        logic signed [SAMPLE_WIDTH-1:0] meas
    );
        longint        err;
        longint        derr;
        longint        integ;
        longint        level;
        drive_result_t r;
        if (op == OP_CLEAR)
        begin
            prev_error     = 0;
            error_integral = 0;
            prev_drive     = 0;
            r.drive        = '0;
            r.held         = 1'b0;
            return r;
        end
        err   = longint'(tgt) - longint'(meas);
        derr  = err - prev_error;
        integ = error_integral + err;
        if (integ > longint'(SUM_MAX))
            integ = longint'(SUM_MAX);
        if (integ < longint'(SUM_MIN))
            integ = longint'(SUM_MIN);
        prev_error     = err;
        error_integral = integ;
        r.held = (err < band_q) && (err > -band_q);
        if (r.held)
            level = prev_drive;
        else
            level = (kp_q * err + ki_q * integ + kd_q * derr) >>> 1;
        // upper bound wins when the bounds cross and level is at or above it
        if (level >= upper_q)
            level = upper_q;
        else if (level <= lower_q)
            level = lower_q;
        prev_drive = level;
        r.drive    = level[DRIVE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_q           = longint'(KP_RESET);
            ki_q           = longint'(KI_RESET);
            kd_q           = longint'(KD_RESET);
            upper_q        = longint'(DRIVE_UPPER_RESET);
            lower_q        = longint'(DRIVE_LOWER_RESET);
            band_q         = longint'(DEAD_BAND_RESET);
            prev_error     = 0;
            error_integral = 0;
            prev_drive     = 0;
            fail_total     = 0;
            pending_drives.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_KP_GAIN:     kp_q    = longint'(cfg_wdata);
                    REG_KI_GAIN:     ki_q    = longint'(cfg_wdata);
                    REG_KD_GAIN:     kd_q    = longint'(cfg_wdata);
                    REG_DRIVE_UPPER: upper_q = longint'($signed(cfg_wdata));
                    REG_DRIVE_LOWER: lower_q = longint'($signed(cfg_wdata));
                    REG_DEAD_BAND:   band_q  = longint'(cfg_wdata);
                    default: ;
                endcase
            end
            // retire before predicting: a request accepted now cannot answer now
            if (m_tvalid && m_tready)
            begin
                if (pending_drives.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected drive result %0d held %0b",
                                 $signed(m_tdata), m_tuser[0]);
                end
                else
                begin
                    want = pending_drives.pop_front();
                    if (m_tdata !== want.drive || m_tuser[0] !== want.held)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("drive mismatch: expected %0d held %0b, got %0d held %0b",
                                     want.drive, want.held, $signed(m_tdata), m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_drives.push_back(step_controller(s_tuser[0],
                    s_tdata[SAMPLE_WIDTH-1:0], s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
            outstanding <= pending_drives.size();
            mismatches  <= fail_total;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Stimulus and verdict for the positional PID core with deadband.
`default_nettype none

module tb_top;
    import ppid_db_pkg::*;

    localparam int     SAMPLE_W       = 16;
    localparam int     DATA_W         = ((2*SAMPLE_W+7)/8)*8;
    localparam int     CLK_PERIOD     = 8;
    localparam longint TIMEOUT_CYCLES = 3000000;
    localparam int     PHASE_ITEMS    = 155;
    localparam int     WINDUP_ITEMS   = 24;
    localparam int     UNWIND_ITEMS   = 16;
    localparam int     SETTLE_ITEMS   = 40;
    localparam int     HOLD_PERIOD    = 1100;
    localparam int     HOLD_PHASE     = 400;
    localparam int     HOLD_CYCLES    = 64;
    localparam int     DRAIN_CYCLES   = 8;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // indexes past the register file, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DRIVE_W-1:0]    m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    outstanding;
    int                    mismatches;

    int burst_left;
    int cur_band;

    positional_pid_with_deadband_core #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    ppid_db_checker #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .DATA_W      (DATA_W)
    ) drive_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .outstanding(outstanding),
        .mismatches (mismatches)
    );

    initial clk = 1'b0;

    always
    begin
        #(CLK_PERIOD/2) clk = 1'b1;
        #(CLK_PERIOD/2) clk = 1'b0;
    end

    // Offer one request and hold it until taken; close the burst with a gap
    task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] tgt,
                                input logic [SAMPLE_W-1:0] meas);
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, tgt};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end
    endtask

    // Stop offering and wait until every request has answered
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                               input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] upper,
                               input logic [CFG_DATA_W-1:0] lower, input logic [CFG_DATA_W-1:0] band);
        wait_idle();
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_DRIVE_UPPER, upper);
        write_reg(REG_DRIVE_LOWER, lower);
        write_reg(REG_DEAD_BAND, band);
        cfg_wen  <= 1'b0;
        cur_band = band;
    endtask

    task automatic random_request();
        int pick;
        int tgt;
        int meas;
        int span;
        pick = $urandom_range(0, 99);
        tgt  = int'($urandom_range(0, 65535)) - 32768;
        meas = int'($urandom_range(0, 65535)) - 32768;
        if (pick < 5)
            send_request(OP_CLEAR, SAMPLE_W'(tgt), SAMPLE_W'(meas));
        else
        begin
            if (pick < 40)
            begin
                // hover around the deadband edges
                span = cur_band + 2;
                meas = tgt - (int'($urandom_range(0, 2*span)) - span);
            end
            else if (pick < 70)
                meas = tgt - (int'($urandom_range(0, 4000)) - 2000);
            else if (pick < 80)
            begin
                tgt  = $urandom_range(0, 1) ? 32767 : -32768;
                meas = $urandom_range(0, 1) ? 32767 : -32768;
            end
            if (meas > 32767)
                meas = 32767;
            if (meas < -32768)
                meas = -32768;
            send_request(OP_COMPUTE, SAMPLE_W'(tgt), SAMPLE_W'(meas));
        end
    endtask

    // Push the integral hard one way, then back off partway
    task automatic windup_run(input int sign);
        int k;
        send_request(OP_CLEAR, '0, '0);
        for (k = 0; k < WINDUP_ITEMS; k++)
            send_request(OP_COMPUTE, sign > 0 ? SAMPLE_MAX : SAMPLE_MIN,
                         sign > 0 ? SAMPLE_MIN : SAMPLE_MAX);
        for (k = 0; k < UNWIND_ITEMS; k++)
            send_request(OP_COMPUTE, sign > 0 ? SAMPLE_MIN : SAMPLE_MAX,
                         sign > 0 ? SAMPLE_MAX : SAMPLE_MIN);
        for (k = 0; k < SETTLE_ITEMS; k++)
            send_request(OP_COMPUTE, SAMPLE_W'(int'($urandom_range(0, 1000)) - 500), '0);
    endtask

    // Receiver: random stall patterns plus a long hold-off at a fixed cadence
    initial
    begin : sink_pattern
        sink_mode_t mode;
        int         seg_len;
        int         cyc;
        cyc = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            mode    = sink_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(4, 48);
            repeat (seg_len)
            begin
                if (cyc % HOLD_PERIOD == HOLD_PHASE)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    cyc += HOLD_CYCLES;
                end
                else
                begin
                    case (mode)
                        SINK_OPEN:   m_tready <= 1'b1;
                        SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                        SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                        default:     m_tready <= ~m_tready;
                    endcase
                    @(posedge clk);
                    cyc++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int         ph;
        shortint    lo_b;
        shortint    hi_b;
        shortint    swap;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_COMPUTE;
        cfg_wen   <= 1'b0;
        cfg_index <= REG_KP_GAIN;
        cfg_wdata <= '0;
        burst_left = $urandom_range(1, 20);
        cur_band   = DEAD_BAND_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, deadband edges, clear
        send_request(OP_CLEAR, 16'h1234, 16'h5678);
        send_request(OP_COMPUTE, 16'sh7FFF, 16'sh8000);
        send_request(OP_COMPUTE, 16'sh8000, 16'sh7FFF);
        send_request(OP_COMPUTE, 0, 0);
        send_request(OP_COMPUTE, 2, 0);
        send_request(OP_COMPUTE, 0, 2);
        send_request(OP_COMPUTE, 3, 0);
        send_request(OP_COMPUTE, -3, 0);
        send_request(OP_COMPUTE, 16'hFFFF, 16'hFFFF);
        send_request(OP_CLEAR, 16'h7FFF, 16'h8000);
        send_request(OP_COMPUTE, 100, 90);

        // Held drive still goes through a narrowed clamp
        send_request(OP_COMPUTE, 16'sh7FFF, 0);
        wait_idle();
        write_reg(REG_DRIVE_UPPER, 16'sd100);
        cfg_wen <= 1'b0;
        send_request(OP_COMPUTE, 1, 0);

        // Writes past the register file, then a zero deadband
        wait_idle();
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        write_reg(REG_DEAD_BAND, 16'h0000);
        cfg_wen  <= 1'b0;
        cur_band = 0;
        send_request(OP_COMPUTE, 5, 5);
        send_request(OP_COMPUTE, 6, 5);

        // Crossed clamp bounds
        wait_idle();
        write_reg(REG_DRIVE_UPPER, -16'sd50);
        write_reg(REG_DRIVE_LOWER, 16'sd50);
        cfg_wen <= 1'b0;
        send_request(OP_COMPUTE, 10, 0);
        send_request(OP_COMPUTE, -1000, 0);
        send_request(OP_COMPUTE, 1000, 0);
        send_request(OP_COMPUTE, 0, 0);

        // Clear leaves the registers alone
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_COMPUTE, 20, 0);

        // Random traffic under a series of register settings
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_config(KP_RESET, KI_RESET, KD_RESET, DRIVE_UPPER_RESET,
                               DRIVE_LOWER_RESET, DEAD_BAND_RESET);
                1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000);
                2: load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
                3: load_config(CFG_DATA_W'($urandom_range(0, 400)),
                               CFG_DATA_W'($urandom_range(0, 400)),
                               CFG_DATA_W'($urandom_range(0, 400)),
                               CFG_DATA_W'(-int'($urandom_range(1, 32768))),
                               CFG_DATA_W'($urandom_range(0, 32767)),
                               CFG_DATA_W'($urandom_range(0, 20)));
                default:
                begin
                    lo_b = shortint'($urandom);
                    hi_b = shortint'($urandom);
                    if (lo_b > hi_b)
                    begin
                        swap = lo_b;
                        lo_b = hi_b;
                        hi_b = swap;
                    end
                    if ($urandom_range(0, 1))
                        load_config(CFG_DATA_W'($urandom_range(0, 65535)),
                                    CFG_DATA_W'($urandom_range(0, 65535)),
                                    CFG_DATA_W'($urandom_range(0, 65535)), hi_b, lo_b,
                                    CFG_DATA_W'($urandom_range(0, 64)));
                    else
                        load_config(CFG_DATA_W'($urandom_range(0, 300)),
                                    CFG_DATA_W'($urandom_range(0, 30)),
                                    CFG_DATA_W'($urandom_range(0, 300)), hi_b, lo_b,
                                    CFG_DATA_W'($urandom_range(0, 64)));
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
        end

        // Large integral in both directions, made visible by backing off
        load_config(16'd1, 16'd1, 16'd1, 16'h7FFF, 16'h8000, 16'h0000);
        windup_run(1);
        windup_run(-1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/ppid_db_pkg.sv
rtl/core/positional_pid_with_deadband_core.sv
verif/ppid_db_checker.sv
verif/tb_top.sv
